FILE: sv/psrg_pkg.sv
// ----------------------------------------------------------------------------
// psrg_pkg: shared types and constants for the per-source reorder gate
// Table sizes, command and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package psrg_pkg;

  localparam int PEER_SLOTS  = 16;
  localparam int HOLD_SLOTS  = 8;
  localparam int MAX_RESULTS = 8;

  localparam int PW    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int HW    = $clog2(HOLD_SLOTS);
  localparam int KW    = $clog2(MAX_RESULTS + 1);
  localparam int CNT_W = $clog2(HOLD_SLOTS + 1);

  localparam logic [3:0]  CAP_RESET = 4'd4;
  localparam logic [31:0] SEQ_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] SEQ_FIRST = 32'd1;

  localparam logic [1:0] CMD_INGEST  = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_SWEEP   = 2'd3;

  localparam logic [1:0] ST_DELIVER = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] src_node;
    logic [31:0] seq_num;
    logic        is_control;
    logic [31:0] payload_handle;
    logic [63:0] expiry_time;
    logic [63:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] source;
    logic [31:0] seq;
    logic [31:0] payload;
    logic [63:0] expiry;
  } res_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PASS,
    OP_LOOK,
    OP_SCAN,
    OP_CLAIM,
    OP_DECIDE,
    OP_RELEASE,
    OP_ADVANCE,
    OP_SW_CHK,
    OP_SW_ACT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   push;
    logic   last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       pass;
    logic       need_scan;
    logic       scan_last;
    logic       sw_last;
    logic       sw_need_push;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [31:0] seq_inc(input logic [31:0] s);
    seq_inc = (s == SEQ_MAX) ? SEQ_FIRST : s + 32'd1;
  endfunction

endpackage

FILE: sv/psrg_in_if.sv
// ----------------------------------------------------------------------------
// psrg_in_if: command channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface psrg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] src_node;
  logic [31:0] seq_num;
  logic        is_control;
  logic [31:0] payload_handle;
  logic [63:0] expiry_time;
  logic [63:0] now_time;

  modport source (output valid, command, src_node, seq_num, is_control,
                  payload_handle, expiry_time, now_time, input ready);
  modport sink   (input valid, command, src_node, seq_num, is_control,
                  payload_handle, expiry_time, now_time, output ready);
endinterface

FILE: sv/psrg_out_if.sv
// ----------------------------------------------------------------------------
// psrg_out_if: result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface psrg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_source;
  logic [31:0] out_seq;
  logic [31:0] out_payload;
  logic [63:0] out_expiry;
  logic        last;

  modport source (output valid, status, out_source, out_seq, out_payload,
                  out_expiry, last, input ready);
  modport sink   (input valid, status, out_source, out_seq, out_payload,
                  out_expiry, last, output ready);
endinterface

FILE: sv/psrg_ctrl.sv
// ----------------------------------------------------------------------------
// psrg_ctrl: sequencing state machine
// Steps each command through the states it needs: lookup, victim scan, update, hold sweep and result push.
// ----------------------------------------------------------------------------
module psrg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  psrg_pkg::dp_stat_t   stat,
  output psrg_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_LOOK, S_SCAN, S_CLAIM, S_DECIDE,
    S_REL, S_ADV, S_SWCHK, S_SWACT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  assign in_ready = ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: psrg_pkg::OP_NONE, push: 1'b0, last: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = psrg_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.command == psrg_pkg::CMD_SWEEP) begin
          state_nxt = S_SWCHK;
        end else if (stat.pass) begin
          cmd.op    = psrg_pkg::OP_PASS;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.op = psrg_pkg::OP_LOOK;
        unique case (stat.command)
          psrg_pkg::CMD_RELEASE: state_nxt = S_REL;
          psrg_pkg::CMD_ADVANCE: state_nxt = S_ADV;
          default:               state_nxt = S_SCAN;
        endcase
      end
      S_SCAN: begin
        if (stat.need_scan) begin
          cmd.op = psrg_pkg::OP_SCAN;
          if (stat.scan_last) state_nxt = S_CLAIM;
        end else begin
          state_nxt = S_CLAIM;
        end
      end
      S_CLAIM: begin
        cmd.op    = psrg_pkg::OP_CLAIM;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op    = psrg_pkg::OP_DECIDE;
        state_nxt = S_EMIT;
      end
      S_REL: begin
        cmd.op    = psrg_pkg::OP_RELEASE;
        state_nxt = S_EMIT;
      end
      S_ADV: begin
        cmd.op    = psrg_pkg::OP_ADVANCE;
        state_nxt = S_EMIT;
      end
      S_SWCHK: begin
        cmd.op    = psrg_pkg::OP_SW_CHK;
        state_nxt = S_SWACT;
      end
      S_SWACT: begin
        // an earlier expired result still sits in the result reg: push it first
        if (!stat.sw_need_push || stat.out_free) begin
          cmd.op    = psrg_pkg::OP_SW_ACT;
          cmd.push  = stat.sw_need_push;
          state_nxt = stat.sw_last ? S_EMIT : S_SWCHK;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

FILE: sv/psrg_datapath.sv
// ----------------------------------------------------------------------------
// psrg_datapath: peer table, hold store and result registers
// Executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module psrg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  psrg_pkg::in_item_t   in_item,
  input  logic                 out_ready,
  output logic                 out_valid,
  output psrg_pkg::res_item_t  out_item,
  output logic                 out_last,
  input  psrg_pkg::ctrl_cmd_t  cmd,
  output psrg_pkg::dp_stat_t   stat
);

  localparam int PS = psrg_pkg::PEER_SLOTS;
  localparam int HS = psrg_pkg::HOLD_SLOTS;
  localparam int PW = psrg_pkg::PW;
  localparam int HW = psrg_pkg::HW;
  localparam int KW = psrg_pkg::KW;
  localparam int CW = psrg_pkg::CNT_W;

  logic [3:0]          cap_r;
  psrg_pkg::in_item_t  it_r;

  logic                peer_valid_r [PS];
  logic [15:0]         peer_src_r   [PS];
  logic [31:0]         peer_next_r  [PS];
  logic [31:0]         peer_stamp_r [PS];
  logic [31:0]         stamp_r;

  logic                hold_valid_r [HS];
  logic [15:0]         hold_src_r   [HS];
  logic [31:0]         hold_seq_r   [HS];
  logic [31:0]         hold_pay_r   [HS];
  logic [63:0]         hold_exp_r   [HS];

  logic [PW-1:0]       pidx_r, scan_idx_r;
  logic                hit_r, create_r, need_scan_r;
  logic [31:0]         lru_stamp_r;

  logic [HW-1:0]       sw_idx_r;
  logic                sw_exp_r, sw_hit_r;
  logic [PW-1:0]       sw_pidx_r;

  psrg_pkg::res_item_t res_r, out_r;
  logic [KW-1:0]       k_r;
  logic                out_valid_r, out_last_r;

  // lookup of the current source
  logic                hit, pfree, nohold;
  logic [PW-1:0]       hit_idx, pfree_idx, nohold_idx;
  logic                peer_has_hold [PS];

  // hold store scans
  logic                held;
  logic                hfree;
  logic [HW-1:0]       hfree_idx;
  logic [CW-1:0]       own_cnt;
  logic                rel_found;
  logic [HW-1:0]       rel_idx;
  logic [31:0]         expect_seq;
  logic [31:0]         sw_target;
  logic [15:0]         sw_src;
  logic                sw_hit;
  logic [PW-1:0]       sw_pidx;
  logic                sw_fwd;

  assign expect_seq = peer_next_r[pidx_r];
  assign sw_src     = hold_src_r[sw_idx_r];
  assign sw_target  = psrg_pkg::seq_inc(hold_seq_r[sw_idx_r]);
  // expired hold moves its source's cursor only forward
  assign sw_fwd     = sw_hit_r && (sw_target > peer_next_r[sw_pidx_r]);

  always_comb begin
    hit = 1'b0; hit_idx = '0;
    pfree = 1'b0; pfree_idx = '0;
    nohold = 1'b0; nohold_idx = '0;
    sw_hit = 1'b0; sw_pidx = '0;
    for (int i = 0; i < PS; i++) begin
      peer_has_hold[i] = 1'b0;
      for (int j = 0; j < HS; j++) begin
        if (hold_valid_r[j] && hold_src_r[j] == peer_src_r[i]) peer_has_hold[i] = 1'b1;
      end
    end
    for (int i = PS - 1; i >= 0; i--) begin
      if (peer_valid_r[i] && peer_src_r[i] == it_r.src_node) begin
        hit = 1'b1; hit_idx = PW'(i);
      end
      if (!peer_valid_r[i]) begin
        pfree = 1'b1; pfree_idx = PW'(i);
      end
      if (peer_valid_r[i] && !peer_has_hold[i]) begin
        nohold = 1'b1; nohold_idx = PW'(i);
      end
      if (peer_valid_r[i] && peer_src_r[i] == sw_src) begin
        sw_hit = 1'b1; sw_pidx = PW'(i);
      end
    end
  end

  always_comb begin
    held = 1'b0;
    hfree = 1'b0; hfree_idx = '0;
    own_cnt = '0;
    rel_found = 1'b0; rel_idx = '0;
    for (int j = HS - 1; j >= 0; j--) begin
      if (hold_valid_r[j] && hold_src_r[j] == it_r.src_node) begin
        own_cnt = own_cnt + CW'(1);
        if (hold_seq_r[j] == it_r.seq_num) held = 1'b1;
        if (hold_seq_r[j] == expect_seq) begin
          rel_found = 1'b1; rel_idx = HW'(j);
        end
      end
      if (!hold_valid_r[j]) begin
        hfree = 1'b1; hfree_idx = HW'(j);
      end
    end
  end

  assign stat.command      = it_r.command;
  // only an ingest bypasses ordering
  assign stat.pass         = (it_r.command == psrg_pkg::CMD_INGEST) &&
                             (it_r.is_control || (it_r.seq_num == 32'd0));
  assign stat.need_scan    = need_scan_r;
  assign stat.scan_last    = (scan_idx_r == PW'(PS - 1));
  assign stat.sw_last      = (sw_idx_r == HW'(HS - 1));
  assign stat.sw_need_push = sw_exp_r && (k_r < KW'(psrg_pkg::MAX_RESULTS)) && (k_r != '0);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= psrg_pkg::CAP_RESET;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PS; i++) peer_valid_r[i] <= 1'b0;
      for (int j = 0; j < HS; j++) hold_valid_r[j] <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;

      if (cmd.push) begin
        out_r       <= res_r;
        out_last_r  <= cmd.last;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (cmd.op)
        psrg_pkg::OP_LOAD: begin
          it_r     <= in_item;
          res_r    <= '{status: psrg_pkg::ST_NONE, default: '0};
          k_r      <= '0;
          sw_idx_r <= '0;
        end
        psrg_pkg::OP_PASS: begin
          res_r <= '{status: psrg_pkg::ST_DELIVER, source: it_r.src_node,
                     seq: it_r.seq_num, payload: it_r.payload_handle,
                     expiry: it_r.expiry_time};
        end
        psrg_pkg::OP_LOOK: begin
          hit_r       <= hit;
          need_scan_r <= !hit && !pfree && !nohold;
          scan_idx_r  <= '0;
          if (hit) begin
            pidx_r <= hit_idx; create_r <= 1'b0;
          end else if (pfree) begin
            pidx_r <= pfree_idx; create_r <= 1'b1;
          end else if (nohold) begin
            pidx_r <= nohold_idx; create_r <= 1'b1;
          end else begin
            pidx_r <= '0; create_r <= 1'b1;
          end
        end
        psrg_pkg::OP_SCAN: begin
          // oldest stamp wins, lowest index on a tie
          if (scan_idx_r == '0 || peer_stamp_r[scan_idx_r] < lru_stamp_r) begin
            pidx_r      <= scan_idx_r;
            lru_stamp_r <= peer_stamp_r[scan_idx_r];
          end
          scan_idx_r <= scan_idx_r + PW'(1);
        end
        psrg_pkg::OP_CLAIM: begin
          if (need_scan_r) begin
            for (int j = 0; j < HS; j++) begin
              if (hold_src_r[j] == peer_src_r[pidx_r]) hold_valid_r[j] <= 1'b0;
            end
          end
          if (create_r) begin
            peer_valid_r[pidx_r] <= 1'b1;
            peer_src_r[pidx_r]   <= it_r.src_node;
            peer_next_r[pidx_r]  <= psrg_pkg::SEQ_FIRST;
          end
          stamp_r              <= stamp_r + 32'd1;
          peer_stamp_r[pidx_r] <= stamp_r + 32'd1;
        end
        psrg_pkg::OP_DECIDE: begin
          if (it_r.seq_num == expect_seq) begin
            res_r <= '{status: psrg_pkg::ST_DELIVER, source: it_r.src_node,
                       seq: it_r.seq_num, payload: it_r.payload_handle,
                       expiry: it_r.expiry_time};
            peer_next_r[pidx_r] <= psrg_pkg::seq_inc(expect_seq);
          end else if (it_r.seq_num > expect_seq && !held) begin
            if ((8'(own_cnt) >= 8'(cap_r)) || !hfree) begin
              res_r <= '{status: psrg_pkg::ST_FULL, default: '0};
            end else begin
              hold_valid_r[hfree_idx] <= 1'b1;
              hold_src_r[hfree_idx]   <= it_r.src_node;
              hold_seq_r[hfree_idx]   <= it_r.seq_num;
              hold_pay_r[hfree_idx]   <= it_r.payload_handle;
              hold_exp_r[hfree_idx]   <= it_r.expiry_time;
            end
          end
        end
        psrg_pkg::OP_RELEASE: begin
          if (hit_r && rel_found) begin
            res_r <= '{status: psrg_pkg::ST_DELIVER, source: hold_src_r[rel_idx],
                       seq: hold_seq_r[rel_idx], payload: hold_pay_r[rel_idx],
                       expiry: hold_exp_r[rel_idx]};
            hold_valid_r[rel_idx] <= 1'b0;
            peer_next_r[pidx_r]   <= psrg_pkg::seq_inc(expect_seq);
          end
        end
        psrg_pkg::OP_ADVANCE: begin
          if (hit_r && it_r.seq_num > expect_seq) begin
            peer_next_r[pidx_r] <= it_r.seq_num;
            for (int j = 0; j < HS; j++) begin
              if (hold_src_r[j] == it_r.src_node && hold_seq_r[j] < it_r.seq_num)
                hold_valid_r[j] <= 1'b0;
            end
          end
        end
        psrg_pkg::OP_SW_CHK: begin
          sw_exp_r  <= hold_valid_r[sw_idx_r] && (hold_exp_r[sw_idx_r] != 64'd0) &&
                       (it_r.now_time >= hold_exp_r[sw_idx_r]);
          sw_hit_r  <= sw_hit;
          sw_pidx_r <= sw_pidx;
        end
        psrg_pkg::OP_SW_ACT: begin
          if (sw_exp_r) begin
            if (k_r < KW'(psrg_pkg::MAX_RESULTS)) begin
              res_r <= '{status: psrg_pkg::ST_EXPIRED, source: sw_src,
                         seq: hold_seq_r[sw_idx_r], payload: hold_pay_r[sw_idx_r],
                         expiry: hold_exp_r[sw_idx_r]};
              k_r   <= k_r + KW'(1);
            end
            if (sw_fwd) peer_next_r[sw_pidx_r] <= sw_target;
            // free the expired hold and any of its source now behind the cursor
            for (int j = 0; j < HS; j++) begin
              if ((HW'(j) == sw_idx_r) ||
                  (sw_fwd && hold_src_r[j] == sw_src && hold_seq_r[j] < sw_target))
                hold_valid_r[j] <= 1'b0;
            end
          end
          sw_idx_r <= sw_idx_r + HW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/per_source_reorder_gate.sv
// ----------------------------------------------------------------------------
// per_source_reorder_gate: per-source in-order delivery gate
// Peer table with next-expected sequence and LRU stamp, plus a hold store
// for early messages; ingest, release, advance and expiry sweep commands.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  in_ch     in         valid/ready      command, source, seq, ctl, handle, times
//  out_ch    out        valid/ready      status, source, seq, handle, expiry, last
//  cfg_*     in         write enable     hold cap per source (4 bits)
//
// Sequencing: one transaction at a time. Pass-through ingest runs load,
//   dispatch, emit; release/advance add lookup and update; ordered ingest
//   adds lookup, claim, decide, plus a serial LRU stamp scan when the table
//   is full and every peer has holds. Sweep checks, then updates, each hold slot.
// Reset: rst_n synchronous; clears peer and hold valid bits, stamp counter
//   and the cap (back to 4). No clearing pass is needed.
// Stalls: a finished result waits in the output register while the next
//   command is accepted; the block only stalls when a new result finds that
//   register still full.
module per_source_reorder_gate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  psrg_in_if.sink     in_ch,
  psrg_out_if.source  out_ch
);

  psrg_pkg::in_item_t  in_item;
  psrg_pkg::res_item_t out_item;
  psrg_pkg::ctrl_cmd_t cmd;
  psrg_pkg::dp_stat_t  stat;
  logic                ready;
  logic                out_valid;
  logic                out_last;

  assign in_item = '{command:        in_ch.command,
                     src_node:       in_ch.src_node,
                     seq_num:        in_ch.seq_num,
                     is_control:     in_ch.is_control,
                     payload_handle: in_ch.payload_handle,
                     expiry_time:    in_ch.expiry_time,
                     now_time:       in_ch.now_time};

  assign in_ch.ready = ready;

  // controller only sees the handshake; the item itself is latched by the datapath
  psrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psrg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_last  (out_last),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_item.status;
  assign out_ch.out_source  = out_item.source;
  assign out_ch.out_seq     = out_item.seq;
  assign out_ch.out_payload = out_item.payload;
  assign out_ch.out_expiry  = out_item.expiry;
  assign out_ch.last        = out_last;

endmodule

FILE: sv/psrg_checker.sv
// ----------------------------------------------------------------------------
// psrg_checker: port-level checks for the reorder gate
// Watches the channel handshakes; bound onto the top level.
// ----------------------------------------------------------------------------
module psrg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one transaction in flight: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // ready comes back only with the final result of the transaction presented
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_last)
    else $error("ready returned without a final result");

endmodule

bind per_source_reorder_gate psrg_checker u_psrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);

FILE: sim/psrg_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psrg_tb_if: testbench types for the gate bench
// Holds the predicted result record shared by the bench top.
// ----------------------------------------------------------------------------
package psrg_tb_pkg;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] source;
    logic [31:0] seq;
    logic [31:0] payload;
    logic [63:0] expiry;
    logic        last;
  } gate_result_t;
endpackage

FILE: sim/tb_per_source_reorder_gate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_source_reorder_gate: self-checking bench for the reorder gate
// Drives commands through the input channel, predicts every result with a
// behavioral copy of the peer table and hold store, and checks each result
// in order under several idling mixes and cap settings.
// ----------------------------------------------------------------------------
module tb_per_source_reorder_gate;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  psrg_in_if  in_ch ();
  psrg_out_if out_ch ();

  per_source_reorder_gate i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // Predicted gate state
  logic        pv_valid [psrg_pkg::PEER_SLOTS];
  logic [15:0] pv_src   [psrg_pkg::PEER_SLOTS];
  logic [31:0] pv_next  [psrg_pkg::PEER_SLOTS];
  logic [31:0] pv_stamp [psrg_pkg::PEER_SLOTS];
  logic [31:0] stamp_ctr;
  logic        hd_valid [psrg_pkg::HOLD_SLOTS];
  logic [15:0] hd_src   [psrg_pkg::HOLD_SLOTS];
  logic [31:0] hd_seq   [psrg_pkg::HOLD_SLOTS];
  logic [31:0] hd_pay   [psrg_pkg::HOLD_SLOTS];
  logic [63:0] hd_exp   [psrg_pkg::HOLD_SLOTS];
  logic [3:0]  hold_cap;

  psrg_tb_pkg::gate_result_t expected_q[$];
  int           err_count;
  int           idle_in_pct;
  int           stall_out_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] next_seq(input logic [31:0] s);
    return (s == 32'hFFFF_FFFF) ? 32'd1 : s + 32'd1;
  endfunction

  function automatic int peer_lookup(input logic [15:0] s);
    for (int i = 0; i < psrg_pkg::PEER_SLOTS; i++)
      if (pv_valid[i] && pv_src[i] == s) return i;
    return -1;
  endfunction

  function automatic int holds_of(input logic [15:0] s);
    int c;
    c = 0;
    for (int j = 0; j < psrg_pkg::HOLD_SLOTS; j++)
      if (hd_valid[j] && hd_src[j] == s) c++;
    return c;
  endfunction

  function automatic int held_slot(input logic [15:0] s, input logic [31:0] q);
    for (int j = 0; j < psrg_pkg::HOLD_SLOTS; j++)
      if (hd_valid[j] && hd_src[j] == s && hd_seq[j] == q) return j;
    return -1;
  endfunction

  function automatic void cursor_advance(input logic [15:0] s, input logic [31:0] tgt);
    int p;
    p = peer_lookup(s);
    if (p < 0 || tgt <= pv_next[p]) return;
    pv_next[p] = tgt;
    for (int j = 0; j < psrg_pkg::HOLD_SLOTS; j++)
      if (hd_valid[j] && hd_src[j] == s && hd_seq[j] < tgt) hd_valid[j] = 1'b0;
  endfunction

  // Peer slot for a source: existing, free, then a victim without holds,
  // else the LRU peer whose holds get flushed.
  function automatic int peer_claim(input logic [15:0] s);
    int idx;
    int lru;
    idx = peer_lookup(s);
    lru = -1;
    if (idx < 0) begin
      for (int i = 0; i < psrg_pkg::PEER_SLOTS && idx < 0; i++)
        if (!pv_valid[i]) idx = i;
      for (int i = 0; i < psrg_pkg::PEER_SLOTS && idx < 0; i++)
        if (holds_of(pv_src[i]) == 0) idx = i;
      if (idx < 0) begin
        for (int i = 0; i < psrg_pkg::PEER_SLOTS; i++)
          if (lru < 0 || pv_stamp[i] < pv_stamp[lru]) lru = i;
        for (int j = 0; j < psrg_pkg::HOLD_SLOTS; j++)
          if (hd_valid[j] && hd_src[j] == pv_src[lru]) hd_valid[j] = 1'b0;
        idx = lru;
      end
      pv_valid[idx] = 1'b1;
      pv_src[idx]   = s;
      pv_next[idx]  = 32'd1;
    end
    stamp_ctr     = stamp_ctr + 32'd1;
    pv_stamp[idx] = stamp_ctr;
    return idx;
  endfunction

  function automatic psrg_tb_pkg::gate_result_t mk(input logic [1:0] st,
      input logic [15:0] s, input logic [31:0] q, input logic [31:0] pl,
      input logic [63:0] ex);
    psrg_tb_pkg::gate_result_t r;
    r.status = st; r.source = s; r.seq = q; r.payload = pl; r.expiry = ex;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out the results of one command and queues them
  function automatic void predict_gate(input psrg_pkg::in_item_t it);
    psrg_tb_pkg::gate_result_t res[$];
    int p;
    int h;
    int f;
    logic [31:0] want;
    res.push_back(mk(psrg_pkg::ST_NONE, '0, '0, '0, '0));
    unique case (it.command)
      psrg_pkg::CMD_INGEST: begin
        if (it.is_control || it.seq_num == 32'd0) begin
          res[0] = mk(psrg_pkg::ST_DELIVER, it.src_node, it.seq_num, it.payload_handle,
                      it.expiry_time);
        end else begin
          p    = peer_claim(it.src_node);
          want = pv_next[p];
          if (it.seq_num == want) begin
            res[0] = mk(psrg_pkg::ST_DELIVER, it.src_node, it.seq_num,
                        it.payload_handle, it.expiry_time);
            pv_next[p] = next_seq(want);
          end else if (it.seq_num > want && held_slot(it.src_node, it.seq_num) < 0) begin
            f = -1;
            if (holds_of(it.src_node) >= int'(hold_cap)) begin
              res[0] = mk(psrg_pkg::ST_FULL, '0, '0, '0, '0);
            end else begin
              for (int j = 0; j < psrg_pkg::HOLD_SLOTS && f < 0; j++)
                if (!hd_valid[j]) f = j;
              if (f < 0) begin
                res[0] = mk(psrg_pkg::ST_FULL, '0, '0, '0, '0);
              end else begin
                hd_valid[f] = 1'b1;
                hd_src[f]   = it.src_node;
                hd_seq[f]   = it.seq_num;
                hd_pay[f]   = it.payload_handle;
                hd_exp[f]   = it.expiry_time;
              end
            end
          end
        end
      end
      psrg_pkg::CMD_RELEASE: begin
        p = peer_lookup(it.src_node);
        if (p >= 0) begin
          h = held_slot(it.src_node, pv_next[p]);
          if (h >= 0) begin
            res[0] = mk(psrg_pkg::ST_DELIVER, hd_src[h], hd_seq[h], hd_pay[h], hd_exp[h]);
            hd_valid[h] = 1'b0;
            pv_next[p]  = next_seq(pv_next[p]);
          end
        end
      end
      psrg_pkg::CMD_ADVANCE: cursor_advance(it.src_node, it.seq_num);
      default: begin
        res.delete();
        for (int j = 0; j < psrg_pkg::HOLD_SLOTS; j++) begin
          if (hd_valid[j] && hd_exp[j] != 64'd0 && it.now_time >= hd_exp[j]) begin
            if (res.size() < psrg_pkg::MAX_RESULTS)
              res.push_back(mk(psrg_pkg::ST_EXPIRED, hd_src[j], hd_seq[j], hd_pay[j],
                               hd_exp[j]));
            cursor_advance(hd_src[j], next_seq(hd_seq[j]));
            hd_valid[j] = 1'b0;
          end
        end
        if (res.size() == 0) res.push_back(mk(psrg_pkg::ST_NONE, '0, '0, '0, '0));
      end
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[k]) expected_q.push_back(res[k]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    psrg_tb_pkg::gate_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_q.pop_front();
        if (out_ch.status !== e.status || out_ch.out_source !== e.source ||
            out_ch.out_seq !== e.seq || out_ch.out_payload !== e.payload ||
            out_ch.out_expiry !== e.expiry || out_ch.last !== e.last)
          report_mismatch($sformatf(
            "got st%0d src%h seq%h pl%h ex%h l%b, exp st%0d src%h seq%h pl%h ex%h l%b",
            out_ch.status, out_ch.out_source, out_ch.out_seq, out_ch.out_payload,
            out_ch.out_expiry, out_ch.last, e.status, e.source, e.seq, e.payload,
            e.expiry, e.last));
      end
    end
  end

  // Receiver stall
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= stall_out_pct);

  task automatic send_cmd(input logic [1:0] c, input logic [15:0] s, input logic [31:0] q,
      input logic ctl, input logic [31:0] pl, input logic [63:0] ex, input logic [63:0] nw);
    psrg_pkg::in_item_t it;
    while ($urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    it.command = c; it.src_node = s; it.seq_num = q; it.is_control = ctl;
    it.payload_handle = pl; it.expiry_time = ex; it.now_time = nw;
    in_ch.valid          <= 1'b1;
    in_ch.command        <= c;
    in_ch.src_node       <= s;
    in_ch.seq_num        <= q;
    in_ch.is_control     <= ctl;
    in_ch.payload_handle <= pl;
    in_ch.expiry_time    <= ex;
    in_ch.now_time       <= nw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_gate(it);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cap(input logic [3:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_cap = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Extremes, every command and the named corner cases
  task automatic test_directed();
    send_cmd(psrg_pkg::CMD_INGEST, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, '1, '1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'h0000, 32'd0, 1'b0, 32'd0, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd0, 32'd1, 1'b0, 32'hA5A5_0001, 64'd7, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd0, 32'd1, 1'b0, 32'd2, 64'd0, 64'd1);     // duplicate
    send_cmd(psrg_pkg::CMD_INGEST, 16'd5, 32'd3, 1'b0, 32'd33, 64'd100, 64'd1);  // held
    send_cmd(psrg_pkg::CMD_INGEST, 16'd5, 32'd3, 1'b0, 32'd34, 64'd100, 64'd1);  // already
    send_cmd(psrg_pkg::CMD_INGEST, 16'd5, 32'd2, 1'b0, 32'd22, 64'd0, 64'd1);    // gap
    send_cmd(psrg_pkg::CMD_RELEASE, 16'd5, 32'd0, 1'b0, 32'd0, 64'd0, 64'd1);    // none at 1
    send_cmd(psrg_pkg::CMD_INGEST, 16'd5, 32'd1, 1'b0, 32'd11, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_RELEASE, 16'd5, 32'd0, 1'b0, 32'd0, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_RELEASE, 16'd5, 32'd0, 1'b1, 32'd0, 64'd0, 64'd1);    // ctl set
    send_cmd(psrg_pkg::CMD_RELEASE, 16'd77, 32'd0, 1'b0, 32'd0, 64'd0, 64'd1);   // unknown
    send_cmd(psrg_pkg::CMD_ADVANCE, 16'd77, 32'd9, 1'b0, 32'd0, 64'd0, 64'd1);   // unknown
    send_cmd(psrg_pkg::CMD_ADVANCE, 16'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd0, 32'hFFFF_FFFF, 1'b0, 32'd9, 64'd0, 64'd1); // wrap
    send_cmd(psrg_pkg::CMD_INGEST, 16'd0, 32'd1, 1'b0, 32'd10, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_ADVANCE, 16'd0, 32'd1, 1'b0, 32'd0, 64'd0, 64'd1);    // not fwd
    send_cmd(psrg_pkg::CMD_INGEST, 16'd9, 32'd5, 1'b0, 32'd1, 64'd50, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd9, 32'd6, 1'b0, 32'd2, 64'd60, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd9, 32'd9, 1'b0, 32'd3, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_SWEEP, 16'd0, 32'd0, 1'b0, 32'd0, 64'd0, 64'd49);     // none
    send_cmd(psrg_pkg::CMD_SWEEP, 16'd0, 32'd0, 1'b0, 32'd0, 64'd0, 64'd50);     // boundary
    send_cmd(psrg_pkg::CMD_SWEEP, 16'd0, 32'd0, 1'b0, 32'd0, 64'd0, '1);
    send_cmd(psrg_pkg::CMD_ADVANCE, 16'd9, 32'd20, 1'b0, 32'd0, 64'd0, 64'd1);   // frees
  endtask

  // Cap of zero drops every early message; cap of one fills at once
  task automatic test_cap_extremes();
    write_cap(4'd0);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd40, 32'd4, 1'b0, 32'd1, 64'd0, 64'd1);
    write_cap(4'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd41, 32'd4, 1'b0, 32'd1, 64'd0, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd41, 32'd5, 1'b0, 32'd2, 64'd0, 64'd1);
    write_cap(4'd15);
  endtask

  // Fill all holds, then overflow the peer table so peers without holds get evicted
  task automatic test_eviction();
    for (int i = 0; i < 8; i++)
      send_cmd(psrg_pkg::CMD_INGEST, 16'd200 + 16'(i), 32'd3, 1'b0, 32'(i), 64'd5, 64'd1);
    send_cmd(psrg_pkg::CMD_INGEST, 16'd300, 32'd3, 1'b0, 32'd0, 64'd0, 64'd1);  // store full
    for (int i = 0; i < 20; i++)
      send_cmd(psrg_pkg::CMD_INGEST, 16'd400 + 16'(i), 32'd1, 1'b0, 32'(i), 64'd0, 64'd1);
    for (int i = 0; i < 10; i++)
      send_cmd(psrg_pkg::CMD_INGEST, 16'd500 + 16'(i), 32'd2, 1'b0, 32'(i), 64'd9, 64'd1);
    send_cmd(psrg_pkg::CMD_SWEEP, 16'd0, 32'd0, 1'b0, 32'd0, 64'd0, '1);
  endtask

  // Mostly well-formed per-source streams over a handful of sources
  task automatic test_random(input int n);
    logic [15:0] s;
    logic [31:0] q;
    logic [63:0] ex;
    logic [63:0] nw;
    int r;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      s  = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'(1000 + $urandom_range(5));
      q  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(8);
      ex = ($urandom_range(3) == 0) ? 64'd0 :
           (($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(100)));
      nw = ($urandom_range(4) == 0) ? rand64() : 64'($urandom_range(120) + 1);
      if (r < 60)
        send_cmd(psrg_pkg::CMD_INGEST, s, q, ($urandom_range(15) == 0), $urandom(), ex,
                 64'd1);
      else if (r < 78)
        send_cmd(psrg_pkg::CMD_RELEASE, s, $urandom(), 1'($urandom_range(1)), $urandom(),
                 rand64(), 64'd1);
      else if (r < 88)
        send_cmd(psrg_pkg::CMD_ADVANCE, s, q, 1'($urandom_range(1)), $urandom(), rand64(),
                 64'd1);
      else
        send_cmd(psrg_pkg::CMD_SWEEP, s, $urandom(), 1'($urandom_range(1)), $urandom(),
                 rand64(), nw);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 4'd0;
    in_ch.valid = 1'b0;
    in_ch.command = psrg_pkg::CMD_INGEST;
    in_ch.src_node = '0;
    in_ch.seq_num = '0;
    in_ch.is_control = 1'b0;
    in_ch.payload_handle = '0;
    in_ch.expiry_time = '0;
    in_ch.now_time = 64'd1;
    err_count = 0;
    idle_in_pct = 0;
    stall_out_pct = 0;
    for (int i = 0; i < psrg_pkg::PEER_SLOTS; i++) begin
      pv_valid[i] = 1'b0; pv_src[i] = '0; pv_next[i] = 32'd1; pv_stamp[i] = '0;
    end
    for (int j = 0; j < psrg_pkg::HOLD_SLOTS; j++) begin
      hd_valid[j] = 1'b0; hd_src[j] = '0; hd_seq[j] = '0; hd_pay[j] = '0; hd_exp[j] = '0;
    end
    stamp_ctr = '0;
    hold_cap  = psrg_pkg::CAP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_cap_extremes();
    test_eviction();
    // idling mixes: none, sender, receiver, both
    write_cap(4'd8);
    test_random(15);
    idle_in_pct = 85;
    write_cap(4'd2);
    test_random(15);
    idle_in_pct = 0; stall_out_pct = 85;
    write_cap(4'd1);
    test_random(15);
    idle_in_pct = 27; stall_out_pct = 27;
    write_cap(4'd4);
    test_random(15);
    stall_out_pct = 0;
    drain_results();

    if (err_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
